/* rtl/archive_directory_flag_repair_unit_assert.svh */
// assertion helpers for the flag repair unit
`ifndef ARCHIVE_DIRECTORY_FLAG_REPAIR_UNIT_ASSERT_SVH
`define ARCHIVE_DIRECTORY_FLAG_REPAIR_UNIT_ASSERT_SVH

// same-cycle implication
`define ADFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ADFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/adfr_pkg.sv */
package adfr_pkg;

    localparam int unsigned OUT_CNT_W  = 24;
    localparam int unsigned QDEPTH     = 2;
    localparam int unsigned QPTR_W     = $clog2(QDEPTH);

    localparam logic [7:0] ALT_CACHE_MASK = 8'h04;
    localparam logic [7:0] FLIP_MASK      = 8'h05;
    localparam logic [7:0] TERM_BYTE      = 8'hFF;

    // chunk record byte positions
    localparam logic [4:0] POS_FLAGS_HI  = 5'd1;
    localparam logic [4:0] POS_META_END  = 5'd29;
    localparam logic [4:0] POS_TERM_LO   = 5'd30;
    localparam logic [4:0] POS_TERM_HI   = 5'd31;
    // file header byte positions
    localparam logic [4:0] POS_PRE_LO    = 5'd4;
    localparam logic [4:0] POS_PRE_HI    = 5'd5;
    localparam logic [4:0] POS_HDR_END   = 5'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                end_of_tree;
        logic                tree_valid;
        logic                commit_repair;
        logic [OUT_CNT_W-1:0] entry_count;
        logic [OUT_CNT_W-1:0] chunk_count;
        logic [OUT_CNT_W-1:0] repaired_chunk_count;
        logic [OUT_CNT_W-1:0] repaired_entry_count;
    } t_out;

    typedef struct packed {
        logic repair_enable;
    } t_cfg;

    // classified word handed from parser to accounting
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       valid;
        logic       inc_chunk;
        logic       inc_rep_chunk;
        logic       inc_entry;
        logic       inc_rep_entry;
    } t_op;

endpackage

/* rtl/adfr_chan_if.sv */
interface adfr_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/adfr_front.sv */
module adfr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_repair_enable,
    input  logic          i_valid,
    input  adfr_pkg::t_in i_data,
    input  logic          i_q_full,
    output logic          o_ready,
    output logic          o_push,
    output adfr_pkg::t_op o_op
);
    import adfr_pkg::*;

    typedef enum logic [3:0] {
        PH_EXT_START, PH_EXT_REST, PH_DIR_START, PH_DIR_REST, PH_FILE_START,
        PH_FILE_REST, PH_HEADER, PH_PRELOAD, PH_CHUNK, PH_TAIL
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [7:0]  r_pre_lo, n_pre_lo;
    logic [15:0] r_pre_rem, n_pre_rem;
    logic        r_term_ff, n_term_ff;
    logic        r_entry_rep, n_entry_rep;
    logic        r_chunk_pend, n_chunk_pend;
    logic        r_tail_nz, n_tail_nz;

    logic [7:0]  b;
    logic [15:0] pre_dec;

    assign b       = i_data.data_byte;
    assign pre_dec = r_pre_rem - 16'd1;
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_pre_lo     = r_pre_lo;
        n_pre_rem    = r_pre_rem;
        n_term_ff    = r_term_ff;
        n_entry_rep  = r_entry_rep;
        n_chunk_pend = r_chunk_pend;
        n_tail_nz    = r_tail_nz;
        o_op         = '0;
        o_op.out_byte = b;
        o_op.last     = i_data.last_byte;

        case (r_phase)
            PH_EXT_START:  n_phase = (b == 8'd0) ? PH_TAIL : PH_EXT_REST;
            PH_EXT_REST:   if (b == 8'd0) n_phase = PH_DIR_START;
            PH_DIR_START:  n_phase = (b == 8'd0) ? PH_EXT_START : PH_DIR_REST;
            PH_DIR_REST:   if (b == 8'd0) n_phase = PH_FILE_START;
            PH_FILE_START: n_phase = (b == 8'd0) ? PH_DIR_START : PH_FILE_REST;
            PH_FILE_REST: begin
                if (b == 8'd0) begin
                    n_phase     = PH_HEADER;
                    n_pos       = '0;
                    n_entry_rep = 1'b0;
                end
            end
            PH_HEADER: begin
                if (r_pos == POS_PRE_LO) begin
                    n_pre_lo = b;
                end else if (r_pos == POS_PRE_HI) begin
                    n_pre_rem = {b, r_pre_lo};
                end
                if (r_pos >= POS_HDR_END) begin
                    n_pos   = '0;
                    n_phase = (r_pre_rem == 16'd0) ? PH_CHUNK : PH_PRELOAD;
                end else begin
                    n_pos = r_pos + 5'd1;
                end
            end
            PH_PRELOAD: begin
                n_pre_rem = pre_dec;
                if (pre_dec == 16'd0) begin
                    n_phase = PH_CHUNK;
                    n_pos   = '0;
                end
            end
            PH_CHUNK: begin
                if (r_pos == POS_FLAGS_HI && (b & ALT_CACHE_MASK) != 8'd0) begin
                    n_chunk_pend = 1'b1;
                    if (i_repair_enable) o_op.out_byte = b ^ FLIP_MASK;
                end
                if (r_pos == POS_META_END && r_chunk_pend) begin
                    o_op.inc_rep_chunk = 1'b1;
                    n_entry_rep        = 1'b1;
                    n_chunk_pend       = 1'b0;
                end
                if (r_pos == POS_TERM_LO) n_term_ff = (b == TERM_BYTE);
                if (r_pos >= POS_TERM_HI) begin
                    o_op.inc_chunk = 1'b1;
                    n_pos          = '0;
                    if (r_term_ff && b == TERM_BYTE) begin
                        o_op.inc_entry     = 1'b1;
                        o_op.inc_rep_entry = r_entry_rep;
                        n_entry_rep        = 1'b0;
                        n_phase            = PH_FILE_START;
                    end
                end else begin
                    n_pos = r_pos + 5'd1;
                end
            end
            PH_TAIL:       if (b != 8'd0) n_tail_nz = 1'b1;
            default: begin
                n_phase   = PH_TAIL;
                n_tail_nz = 1'b1;
            end
        endcase

        o_op.valid = (n_phase == PH_TAIL) && !n_tail_nz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_push && i_data.last_byte)) begin
            r_phase      <= PH_EXT_START;
            r_pos        <= '0;
            r_pre_lo     <= '0;
            r_pre_rem    <= '0;
            r_term_ff    <= 1'b0;
            r_entry_rep  <= 1'b0;
            r_chunk_pend <= 1'b0;
            r_tail_nz    <= 1'b0;
        end else if (o_push) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_pre_lo     <= n_pre_lo;
            r_pre_rem    <= n_pre_rem;
            r_term_ff    <= n_term_ff;
            r_entry_rep  <= n_entry_rep;
            r_chunk_pend <= n_chunk_pend;
            r_tail_nz    <= n_tail_nz;
        end
    end
endmodule

/* rtl/adfr_fifo.sv */
module adfr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  adfr_pkg::t_op i_op,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output adfr_pkg::t_op o_op
);
    import adfr_pkg::*;

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

/* rtl/adfr_back.sv */
module adfr_back #(
    parameter int unsigned COUNT_BITS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  adfr_pkg::t_op  i_op,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output adfr_pkg::t_out o_data
);
    import adfr_pkg::*;

    logic [COUNT_BITS-1:0] r_ent, r_chk, r_rchk, r_rent;
    logic [COUNT_BITS-1:0] n_ent, n_chk, n_rchk, n_rent;
    logic                  r_out_valid;
    t_out                  r_out;

    function automatic logic [COUNT_BITS-1:0] sat_inc(
        input logic [COUNT_BITS-1:0] v,
        input logic                  en
    );
        logic [COUNT_BITS-1:0] res;
        res = v;
        if (en && v != '1) res = v + COUNT_BITS'(1);
        return res;
    endfunction

    assign o_pop   = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign n_ent  = sat_inc(r_ent,  i_op.inc_entry);
    assign n_chk  = sat_inc(r_chk,  i_op.inc_chunk);
    assign n_rchk = sat_inc(r_rchk, i_op.inc_rep_chunk);
    assign n_rent = sat_inc(r_rent, i_op.inc_rep_entry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ent       <= '0;
            r_chk       <= '0;
            r_rchk      <= '0;
            r_rent      <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                // counts restart as the tree summary is loaded into the output register
                r_ent  <= i_op.last ? '0 : n_ent;
                r_chk  <= i_op.last ? '0 : n_chk;
                r_rchk <= i_op.last ? '0 : n_rchk;
                r_rent <= i_op.last ? '0 : n_rent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.out_byte    <= i_op.out_byte;
            r_out.end_of_tree <= i_op.last;
            if (i_op.last) begin
                r_out.tree_valid           <= i_op.valid;
                r_out.commit_repair        <= i_op.valid && (n_rchk != '0);
                r_out.entry_count          <= OUT_CNT_W'(n_ent);
                r_out.chunk_count          <= OUT_CNT_W'(n_chk);
                r_out.repaired_chunk_count <= OUT_CNT_W'(n_rchk);
                r_out.repaired_entry_count <= OUT_CNT_W'(n_rent);
            end else begin
                r_out.tree_valid           <= 1'b0;
                r_out.commit_repair        <= 1'b0;
                r_out.entry_count          <= '0;
                r_out.chunk_count          <= '0;
                r_out.repaired_chunk_count <= '0;
                r_out.repaired_entry_count <= '0;
            end
        end
    end

`include "archive_directory_flag_repair_unit_assert.svh"

    `ADFR_ASSERT_NEXT(a_cnt_restart, o_pop && i_op.last, r_chk == '0 && r_rchk == '0, "counts not cleared after tree end")
    `ADFR_ASSERT_NOW(a_commit_valid, r_out_valid && r_out.commit_repair, r_out.tree_valid && r_out.end_of_tree, "commit without valid tree")
    `ADFR_ASSERT_NOW(a_rep_le_chk, 1'b1, r_rent <= r_ent, "repaired entries exceed entries")
endmodule

/* rtl/archive_directory_flag_repair_unit.sv */
// channel  dir  handshake      payload
// i_in     in   valid/ready    data_byte, last_byte
// o_out    out  valid/ready    out_byte, end_of_tree, tree_valid, commit_repair, counts
// i_cfg    in   valid/ready    repair_enable
//
// one word per cycle while o_out.ready is high; a taken word passes through the queue, then the output register
// the parser only stalls when the two-entry queue is full; the queue fills
// only while the output register is held by o_out.ready low
// i_rst_n is synchronous; the parser, counters and repair_enable clear
// parser and counters restart by themselves after a word with last_byte set
module archive_directory_flag_repair_unit #(
    parameter int unsigned COUNT_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    adfr_chan_if.sink     i_in,
    adfr_chan_if.source   o_out,
    adfr_chan_if.sink     i_cfg
);
    import adfr_pkg::*;

    logic r_repair_enable;
    logic q_full, q_valid, push, pop;
    t_op  f_op, q_op;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repair_enable <= 1'b0;
        end else if (i_cfg.valid) begin
            r_repair_enable <= i_cfg.data.repair_enable;
        end
    end

    adfr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_repair_enable (r_repair_enable),
        .i_valid         (i_in.valid),
        .i_data          (i_in.data),
        .i_q_full        (q_full),
        .o_ready         (i_in.ready),
        .o_push          (push),
        .o_op            (f_op)
    );

    adfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (f_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    adfr_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (q_op),
        .o_pop     (pop),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_data    (o_out.data)
    );
endmodule
